// ===== rtl/fit_policy_block_allocator_top_assert.svh =====
// Assertion macros for the fit-policy block allocator.
// Used by fit_policy_block_allocator_top; no other dependencies.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fpba_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // Fit policies.
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;
    localparam logic [1:0] POLICY_NEXT  = 2'd3;

    // Register indexes (address bit 2) and config bus width.
    localparam int         PADDR_W         = 3;
    localparam logic       REG_FIT_POLICY  = 1'b0;
    localparam logic       REG_BLOCK_COUNT = 1'b1;

    // Register reset values.
    localparam logic [1:0] FIT_POLICY_RST  = POLICY_FIRST;
    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0] fit_policy;
        logic [4:0] block_count;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  block_index;
        logic [15:0] item_size;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining_after;
    } out_item_t;

endpackage

// ===== rtl/fpba_regs.sv =====
// APB-style configuration registers: fit policy and block count.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpba_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output fpba_pkg::cfg_t               cfg
);

    fpba_pkg::cfg_t cfg_reg;
    fpba_pkg::cfg_t cfg_next;
    logic           wr_go;

    assign pready = 1'b1;
    assign wr_go  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_go)
        begin
            unique case (paddr[2])
                fpba_pkg::REG_FIT_POLICY:  cfg_next.fit_policy  = pwdata[1:0];
                fpba_pkg::REG_BLOCK_COUNT: cfg_next.block_count = pwdata[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fpba_pkg::REG_FIT_POLICY:  prdata = 32'(cfg_reg.fit_policy);
            fpba_pkg::REG_BLOCK_COUNT: prdata = 32'(cfg_reg.block_count);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fit_policy  <= fpba_pkg::FIT_POLICY_RST;
            cfg_reg.block_count <= fpba_pkg::BLOCK_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/fpba_table.sv =====
// Remaining-size table: one write port, one registered read port.
// Depends on fpba_pkg only through its parameters.
`timescale 1ns / 1ps

module fpba_table
#(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
    localparam int IDX_W     = $clog2(NUM_BLOCKS)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SIZE_BITS-1:0] rd_data
);

    // Contents undefined until loaded; no reset.
    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/fpba_alu.sv =====
// Shared compare/subtract unit: fit test, best/worst compare, final subtraction.
// Depends on fpba_pkg only through its parameters.
`timescale 1ns / 1ps

module fpba_alu
#(
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
)
(
    input  logic [SIZE_BITS-1:0] op_a,
    input  logic [SIZE_BITS-1:0] op_req,
    input  logic [SIZE_BITS-1:0] op_ref,
    output logic                 ge_req,
    output logic                 lt_ref,
    output logic                 gt_ref,
    output logic [SIZE_BITS-1:0] diff
);

    logic [SIZE_BITS:0] sub_w;

    // Borrow out of a - req clear means a >= req.
    assign sub_w  = {1'b0, op_a} - {1'b0, op_req};
    assign ge_req = !sub_w[SIZE_BITS];
    assign diff   = sub_w[SIZE_BITS-1:0];
    assign lt_ref = op_a < op_ref;
    assign gt_ref = op_a > op_ref;

endmodule

// ===== rtl/fpba_seq.sv =====
// Allocation sequencer: scans the table one entry per cycle through the
// shared compare unit and writes back the chosen block. Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_seq
#(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
    localparam int IDX_W     = $clog2(NUM_BLOCKS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpba_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fpba_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fpba_pkg::out_item_t  out_data,
    output logic                 tbl_wr_en,
    output logic [IDX_W-1:0]     tbl_wr_addr,
    output logic [SIZE_BITS-1:0] tbl_wr_data,
    output logic [IDX_W-1:0]     tbl_rd_addr,
    input  logic [SIZE_BITS-1:0] tbl_rd_data
);

    localparam int CNT_W = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
    localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t               state_reg, state_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 eval_vld_reg, eval_vld_next;
    logic                 eval_last_reg, eval_last_next;
    logic [IDX_W-1:0]     eval_pos_reg, eval_pos_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic                 out_valid_reg, out_valid_next;
    fpba_pkg::out_item_t  out_data_reg, out_data_next;

    logic                 accept;
    logic [CNT_W-1:0]     blk_ext;
    logic                 load_ok;
    logic [CNT_W-1:0]     cnt_ext;
    logic [CNT_W-1:0]     n_now;
    logic [IDX_W-1:0]     start_pos;
    logic [31:0]          size_w;
    logic [SIZE_BITS-1:0] req_now;
    logic [IDX_W-1:0]     pos_wrap;
    logic                 issuing;
    logic                 scan_pol;
    logic                 out_free;
    logic [SIZE_BITS-1:0] alu_a;
    logic                 alu_ge, alu_lt, alu_gt;
    logic [SIZE_BITS-1:0] alu_diff;
    logic [31:0]          diff_w;
    logic [31:0]          pick_w;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign blk_ext     = CNT_W'(in_data.block_index);
    assign load_ok     = blk_ext < NUM_CNT;
    assign cnt_ext     = CNT_W'(cfg.block_count);
    assign n_now       = (cnt_ext > NUM_CNT) ? NUM_CNT : cnt_ext;
    assign size_w      = 32'(in_data.item_size);
    assign req_now     = size_w[SIZE_BITS-1:0];
    assign start_pos   = (cfg.fit_policy == fpba_pkg::POLICY_NEXT && CNT_W'(ptr_reg) < n_now)
                         ? ptr_reg : '0;
    assign pos_wrap    = (CNT_W'(pos_reg) + CNT_W'(1) == n_reg) ? '0 : pos_reg + IDX_W'(1);
    assign issuing     = (state_reg == ST_SCAN) && (issue_cnt_reg != n_reg);
    // First and next fit stop at the first hit; best and worst see every entry.
    assign scan_pol    = (cfg.fit_policy == fpba_pkg::POLICY_FIRST)
                      || (cfg.fit_policy == fpba_pkg::POLICY_NEXT);
    assign tbl_rd_addr = pos_reg;

    // Scan: fit test of the read entry; finish: chosen size minus request.
    assign alu_a  = (state_reg == ST_FINISH) ? best_val_reg : tbl_rd_data;
    assign diff_w = 32'(alu_diff);
    assign pick_w = 32'(best_idx_reg);

    fpba_alu #(
        .SIZE_BITS (SIZE_BITS)
    ) u_alu (
        .op_a   (alu_a),
        .op_req (req_reg),
        .op_ref (best_val_reg),
        .ge_req (alu_ge),
        .lt_ref (alu_lt),
        .gt_ref (alu_gt),
        .diff   (alu_diff)
    );

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        n_next         = n_reg;
        issue_cnt_next = issue_cnt_reg;
        pos_next       = pos_reg;
        eval_vld_next  = issuing;
        eval_last_next = eval_last_reg;
        eval_pos_next  = eval_pos_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = blk_ext[IDX_W-1:0];
        tbl_wr_data    = req_now;

        if (issuing)
        begin
            pos_next       = pos_wrap;
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
            eval_pos_next  = pos_reg;
            eval_last_next = (issue_cnt_reg + CNT_W'(1) == n_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.mode == fpba_pkg::MODE_LOAD)
                begin
                    if (load_ok)
                    begin
                        tbl_wr_en = 1'b1;
                        ptr_next  = '0;
                    end
                end
                else if (accept)
                begin
                    req_next       = req_now;
                    n_next         = n_now;
                    issue_cnt_next = '0;
                    pos_next       = start_pos;
                    found_next     = 1'b0;
                    state_next     = (n_now == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (eval_vld_reg)
                begin
                    if (alu_ge && (scan_pol || !found_reg
                        || (cfg.fit_policy == fpba_pkg::POLICY_BEST && alu_lt)
                        || (cfg.fit_policy == fpba_pkg::POLICY_WORST && alu_gt)))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = eval_pos_reg;
                        best_val_next = tbl_rd_data;
                    end
                    if ((alu_ge && scan_pol) || eval_last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (found_reg)
                    begin
                        out_data_next.granted         = 1'b1;
                        out_data_next.chosen_block    = pick_w[3:0];
                        out_data_next.remaining_after = diff_w[15:0];
                        tbl_wr_en   = 1'b1;
                        tbl_wr_addr = best_idx_reg;
                        tbl_wr_data = alu_diff;
                        if (cfg.fit_policy == fpba_pkg::POLICY_NEXT)
                        begin
                            ptr_next = best_idx_reg;
                        end
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            n_reg         <= '0;
            issue_cnt_reg <= '0;
            pos_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            eval_last_reg <= 1'b0;
            eval_pos_reg  <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            n_reg         <= n_next;
            issue_cnt_reg <= issue_cnt_next;
            pos_reg       <= pos_next;
            eval_vld_reg  <= eval_vld_next;
            eval_last_reg <= eval_last_next;
            eval_pos_reg  <= eval_pos_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_val_reg  <= best_val_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

// ===== rtl/fit_policy_block_allocator_top.sv =====
// Fit-policy block allocator, top level: config registers, size table,
// scan sequencer. Depends on fpba_pkg, fpba_regs, fpba_table, fpba_seq, fpba_alu.
`timescale 1ns / 1ps
`include "fit_policy_block_allocator_top_assert.svh"

// Channel   Dir   Handshake              Payload
// in        in    in_valid / in_stall    in_data   (fpba_pkg::in_item_t)
// out       out   out_valid / out_stall  out_data  (fpba_pkg::out_item_t)
// cfg       in    psel/penable/pready    paddr, pwdata, prdata (APB-style)
//
// Flow: a load is written to the table on its transfer; the next transfer
//   may follow at once. An allocate holds in_stall from its transfer until
//   its result is written back: the single table read port is scanned one
//   entry per cycle, each read registered, then the chosen entry is written
//   back. First and next fit stop early at the first hit. With no blocks in
//   use the scan is skipped.
// Reset: rst_n async, active low; config to first fit / 16 blocks, next-fit
//   pointer to 0. Table contents are undefined until loaded (no clearing pass).
// Stalls: one output register; a new item is taken while a result waits, but
//   the write-back cycle holds until the output register is free.

module fit_policy_block_allocator_top
#(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  fpba_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output fpba_pkg::out_item_t          out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpba_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    fpba_pkg::cfg_t       cfg;
    logic                 tbl_wr_en;
    logic [IDX_W-1:0]     tbl_wr_addr;
    logic [SIZE_BITS-1:0] tbl_wr_data;
    logic [IDX_W-1:0]     tbl_rd_addr;
    logic [SIZE_BITS-1:0] tbl_rd_data;

    // Config registers: the user must write them only while the block is idle; the block does not enforce it.
    fpba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Remaining-size table; read data is registered and comes in the cycle after the address.
    fpba_table #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // Sequencer with the shared compare/subtract unit and the output register.
    fpba_seq #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data)
    );

    // A refusal carries zero index and zero size.
    `FPBA_ASSERT_IMP(a_refuse_zero, clk, rst_n, out_valid && !out_data.granted, out_data.chosen_block == 4'd0 && out_data.remaining_after == 16'd0, "refused result not zero")
    // An allocate transfer makes the block busy.
    `FPBA_ASSERT_NXT(a_alloc_busy, clk, rst_n, in_valid && !in_stall && in_data.mode == fpba_pkg::MODE_ALLOC, in_stall, "allocate did not start a scan")
    // A load finishes in its own cycle.
    `FPBA_ASSERT_NXT(a_load_quick, clk, rst_n, in_valid && !in_stall && in_data.mode == fpba_pkg::MODE_LOAD, !in_stall, "load left the block busy")

endmodule
